[rtl/spi_pkg.sv]
// Package for the speed profile interpolator: status codes, states, entry type and constants.
`default_nettype none

package spi_pkg;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [2:0] ST_STORED = 3'd0;
   localparam logic [2:0] ST_TICK   = 3'd1;
   localparam logic [2:0] ST_ORDER  = 3'd2;
   localparam logic [2:0] ST_FULL   = 3'd3;
   localparam logic [2:0] ST_EMPTY  = 3'd4;

   localparam int TIME_W  = 32;
   localparam int SPEED_W = 16;
   localparam int STEP_W  = 16;
   localparam int OUTV_W  = 15;
   localparam int DIST_W  = 31;

   // ceil(2^21 / 9): floor(x * RECIP9 >> 21) equals floor(x / 9) for x below 2^21
   localparam int          RECIP9_SHIFT = 21;
   localparam logic [17:0] RECIP9       = 18'd233017;

   typedef struct packed {
      logic        [TIME_W-1:0]  time_ms;
      logic signed [SPEED_W-1:0] speed;
   } spi_entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLASSIFY,
      S_SEARCH,
      S_PROBE,
      S_FETCH_LO,
      S_DIFF,
      S_MULT,
      S_DIVIDE,
      S_ADJUST,
      S_SCALE,
      S_OUTPUT
   } spi_state_type;

endpackage

`default_nettype wire

[rtl/speed_profile_interpolator.sv]
// Speed profile interpolator: breakpoint table in a memory with search, divide and scaling.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+-----------------------------------
//   request | req_command, req_point_*, req_sim_*,   | taken when start is high and busy
//           | req_time_step_ms                       | is low
//   result  | rsp_status, rsp_set_speed,             | rsp_strobe high for one cycle,
//           | rsp_distance_moved, rsp_relative_time_ms| no back pressure
//
// An append or a tick on an empty table is decided in the cycle it is taken; its result
// shows in the next cycle and busy stays low. A tick at or outside the ends of the table
// keeps busy high through the classify, scale and output states. A tick that interpolates
// keeps busy high through classify, the binary search (a search and a probe state per step
// over the table memory's single read port), fetch, diff and mult, sixteen steps of the
// serial divider, then adjust, scale and output. Its result shows in the cycle busy falls.
// Reset clears the point count and trigger; the table itself is not cleared.
`default_nettype none

module speed_profile_interpolator
   import spi_pkg::*;
#(
   parameter int MAX_POINTS = 256
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_command,
   input  wire logic        [TIME_W-1:0]   req_point_time_ms,
   input  wire logic signed [SPEED_W-1:0]  req_point_speed,
   input  wire logic        [TIME_W-1:0]   req_sim_time_ms,
   input  wire logic        [STEP_W-1:0]   req_time_step_ms,
   output logic                            rsp_strobe,
   output logic             [2:0]          rsp_status,
   output logic             [OUTV_W-1:0]   rsp_set_speed,
   output logic             [DIST_W-1:0]   rsp_distance_moved,
   output logic             [TIME_W-1:0]   rsp_relative_time_ms
);

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_POINTS);
   localparam int PROD_W = 36;

   // table memory
   spi_entry_type mem [MAX_POINTS];
   spi_entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   spi_entry_type    mem_wdata;

   spi_state_type state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [TIME_W-1:0]         first_time_ff, first_time_in;
   logic signed [SPEED_W-1:0] first_speed_ff, first_speed_in;
   logic [TIME_W-1:0]         last_time_ff, last_time_in;
   logic [TIME_W-1:0]         trig_time_ff, trig_time_in;
   logic                      trig_cap_ff, trig_cap_in;
   logic [TIME_W-1:0]         rel_ff, rel_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [IDX_W-1:0]          lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [TIME_W-1:0]         hi_time_ff, hi_time_in;
   logic signed [SPEED_W-1:0] hi_speed_ff, hi_speed_in;
   logic signed [SPEED_W-1:0] base_ff, base_in;
   logic [TIME_W-1:0]         dt_ff, dt_in, den_ff, den_in;
   logic                      neg_ff, neg_in;
   logic [SPEED_W-1:0]        mag_ff, mag_in;
   logic [TIME_W-1:0]         rem_ff, rem_in;
   logic [SPEED_W-1:0]        low_ff, low_in, quo_ff, quo_in;
   logic [3:0]                cnt_ff, cnt_in;
   logic signed [17:0]        v_ff, v_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic                      strobe_ff, strobe_in;
   logic [2:0]                status_ff, status_in;
   logic [OUTV_W-1:0]         speed_ff, speed_in;
   logic [DIST_W-1:0]         dist_ff, dist_in;
   logic [TIME_W-1:0]         rel_out_ff, rel_out_in;

   logic [TIME_W-1:0]   trig_sel;
   logic [IDX_W:0]      mid_sum;
   logic signed [16:0]  ds;
   logic [47:0]         num;
   logic [TIME_W:0]     shifted;
   logic                ge;
   logic signed [17:0]  q_signed;
   logic [OUTV_W-1:0]   v_clamp;
   logic [17:0]         x5;
   logic [OUTV_W-1:0]   speed_now;
   logic [TIME_W-1:0]   hi_idx_full;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      first_time_in  = first_time_ff;
      first_speed_in = first_speed_ff;
      last_time_in   = last_time_ff;
      trig_time_in   = trig_time_ff;
      trig_cap_in    = trig_cap_ff;
      rel_in         = rel_ff;
      step_in        = step_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      hi_time_in     = hi_time_ff;
      hi_speed_in    = hi_speed_ff;
      base_in        = base_ff;
      dt_in          = dt_ff;
      den_in         = den_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      rem_in         = rem_ff;
      low_in         = low_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      v_in           = v_ff;
      prod_in        = prod_ff;
      strobe_in      = 1'b0;
      status_in      = status_ff;
      speed_in       = speed_ff;
      dist_in        = dist_ff;
      rel_out_in     = rel_out_ff;
      rd_addr        = '0;
      mem_we         = 1'b0;
      mem_wdata.time_ms = req_point_time_ms;
      mem_wdata.speed   = req_point_speed;

      trig_sel    = trig_cap_ff ? trig_time_ff : req_sim_time_ms;
      mid_sum     = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;
      hi_idx_full = TIME_W'(count_ff) - 32'd1;
      ds          = 17'(hi_speed_ff) - 17'(rd_data_ff.speed);
      num         = 48'(dt_ff) * 48'(mag_ff);
      shifted     = {rem_ff, low_ff[SPEED_W-1]};
      ge          = (shifted >= {1'b0, den_ff});
      q_signed    = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
      v_clamp     = v_ff[17] ? '0 : v_ff[OUTV_W-1:0];
      x5          = {1'b0, v_clamp, 2'b00} + {3'b000, v_clamp};
      speed_now   = prod_ff[RECIP9_SHIFT +: OUTV_W];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               strobe_in  = 1'b1;
               speed_in   = '0;
               dist_in    = '0;
               rel_out_in = '0;
               if (req_command == CMD_APPEND) begin
                  if (count_ff == FULL_COUNT) begin
                     status_in = ST_FULL;
                  end else if (count_ff != '0 && req_point_time_ms < last_time_ff) begin
                     status_in = ST_ORDER;
                  end else begin
                     status_in    = ST_STORED;
                     mem_we       = 1'b1;
                     count_in     = count_ff + 1'b1;
                     last_time_in = req_point_time_ms;
                     if (count_ff == '0) begin
                        first_time_in  = req_point_time_ms;
                        first_speed_in = req_point_speed;
                     end
                  end
               end else if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  // hold the result until the lookup is done
                  strobe_in    = 1'b0;
                  trig_time_in = trig_sel;
                  trig_cap_in  = 1'b1;
                  rel_in       = (req_sim_time_ms >= trig_sel) ?
                                 req_sim_time_ms - trig_sel : '0;
                  step_in      = req_time_step_ms;
                  state_in     = S_CLASSIFY;
               end
            end
         end
         S_CLASSIFY: begin
            if (rel_ff <= first_time_ff) begin
               v_in     = 18'(first_speed_ff);
               state_in = S_SCALE;
            end else if (rel_ff >= last_time_ff) begin
               v_in     = '0;
               state_in = S_SCALE;
            end else begin
               lo_in    = IDX_W'(1);
               hi_in    = hi_idx_full[IDX_W-1:0];
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (lo_ff == hi_ff) begin
               rd_addr  = lo_ff;
               state_in = S_FETCH_LO;
            end else begin
               rd_addr  = mid_sum[IDX_W-1:0];
               mid_in   = mid_sum[IDX_W-1:0];
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (rd_data_ff.time_ms < rel_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SEARCH;
         end
         S_FETCH_LO: begin
            hi_time_in  = rd_data_ff.time_ms;
            hi_speed_in = rd_data_ff.speed;
            rd_addr     = lo_ff - 1'b1;
            state_in    = S_DIFF;
         end
         S_DIFF: begin
            dt_in    = rel_ff - rd_data_ff.time_ms;
            den_in   = hi_time_ff - rd_data_ff.time_ms;
            base_in  = rd_data_ff.speed;
            neg_in   = ds[16];
            mag_in   = ds[16] ? SPEED_W'(-ds) : ds[SPEED_W-1:0];
            state_in = S_MULT;
         end
         S_MULT: begin
            // quotient stays below 2^16, so the upper word is already below the divisor
            rem_in   = num[47:16];
            low_in   = num[15:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            rem_in = ge ? TIME_W'(shifted - {1'b0, den_ff}) : shifted[TIME_W-1:0];
            low_in = {low_ff[SPEED_W-2:0], 1'b0};
            quo_in = {quo_ff[SPEED_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd15) begin
               state_in = S_ADJUST;
            end
         end
         S_ADJUST: begin
            v_in     = 18'(base_ff) + q_signed;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            prod_in  = PROD_W'(x5) * PROD_W'(RECIP9);
            state_in = S_OUTPUT;
         end
         S_OUTPUT: begin
            strobe_in  = 1'b1;
            status_in  = ST_TICK;
            speed_in   = speed_now;
            dist_in    = DIST_W'(speed_now) * DIST_W'(step_ff);
            rel_out_in = rel_ff;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         trig_time_ff <= '0;
         trig_cap_ff <= 1'b0;
         strobe_ff   <= 1'b0;
         status_ff   <= ST_STORED;
         speed_ff    <= '0;
         dist_ff     <= '0;
         rel_out_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         trig_time_ff <= trig_time_in;
         trig_cap_ff <= trig_cap_in;
         strobe_ff   <= strobe_in;
         status_ff   <= status_in;
         speed_ff    <= speed_in;
         dist_ff     <= dist_in;
         rel_out_ff  <= rel_out_in;
      end
   end

   always_ff @(posedge clock) begin
      first_time_ff  <= first_time_in;
      first_speed_ff <= first_speed_in;
      last_time_ff   <= last_time_in;
      rel_ff         <= rel_in;
      step_ff        <= step_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      hi_time_ff     <= hi_time_in;
      hi_speed_ff    <= hi_speed_in;
      base_ff        <= base_in;
      dt_ff          <= dt_in;
      den_ff         <= den_in;
      neg_ff         <= neg_in;
      mag_ff         <= mag_in;
      rem_ff         <= rem_in;
      low_ff         <= low_in;
      quo_ff         <= quo_in;
      cnt_ff         <= cnt_in;
      v_ff           <= v_in;
      prod_ff        <= prod_in;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_status           = status_ff;
   assign rsp_set_speed        = speed_ff;
   assign rsp_distance_moved   = dist_ff;
   assign rsp_relative_time_ms = rel_out_ff;

endmodule

`default_nettype wire
